// ----- rtl/battery_charge_supervisor_assert.svh -----
// assertion macros for the battery charge supervisor
`ifndef BATTERY_CHARGE_SUPERVISOR_ASSERT_SVH
`define BATTERY_CHARGE_SUPERVISOR_ASSERT_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define BCS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bcs assertion failed");
// consequent holds in the cycle after the antecedent
`define BCS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcs assertion failed");
`else
`define BCS_ASSERT(name, prop)
`define BCS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ----- rtl/bcs_pkg.sv -----
// types and constants for the battery charge supervisor
`default_nettype none

package bcs_pkg;

  localparam int unsigned AvgCountDef   = 10;
  localparam int unsigned SampleBitsDef = 12;

  localparam int unsigned ThreshW = 12;
  localparam int unsigned DebW    = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned ColdSevereRst = 3500;
  localparam int unsigned ColdRst       = 3000;
  localparam int unsigned NormalRst     = 1200;
  localparam int unsigned WarmRst       = 1000;
  localparam logic [DebW-1:0] DebounceRst = 4'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgColdSevere = 3'd0,
    CfgCold       = 3'd1,
    CfgNormal     = 3'd2,
    CfgWarm       = 3'd3,
    CfgDebounce   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    LvlColdest = 3'd0,
    LvlCold    = 3'd1,
    LvlNormal  = 3'd2,
    LvlWarm    = 3'd3,
    LvlHot     = 3'd4
  } temp_level_e;

  typedef struct packed {
    logic [11:0] ntc_sample;
    logic        dc_removed;
    logic        status_charging_pin;
    logic        status_done_pin;
  } bcs_in_t;

  typedef struct packed {
    logic [2:0] temperature_level;
    logic       over_limit;
    logic       charge_enable;
    logic       charge_complete;
    logic       charging_seen;
  } bcs_out_t;

  typedef struct packed {
    logic            state;
    logic [DebW-1:0] cnt;
  } deb_t;

  // one debounce step; high_read is the raw pin level
  function automatic deb_t deb_step(deb_t cur, logic high_read, logic [DebW-1:0] reload);
    deb_t            nxt;
    logic            agrees;
    logic [DebW-1:0] dec;
    nxt    = cur;
    agrees = cur.state ? ~high_read : high_read;
    dec    = cur.cnt - DebW'(1);
    if (agrees) begin
      nxt.cnt = reload;
    end else if (cur.cnt != '0) begin
      if (dec == '0) begin
        nxt.cnt   = reload;
        nxt.state = ~cur.state;
      end else begin
        nxt.cnt = dec;
      end
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/battery_charge_supervisor.sv -----
// battery charge supervisor: one result item per accepted tick item
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle; ready falls only while both registers hold unaccepted items
// classification compares the running sum against thresholds pre-scaled by AVG_COUNT
// reset (async, active low): empty pipeline, level normal, charging disabled, default thresholds
`default_nettype none

module battery_charge_supervisor
  import bcs_pkg::*;
#(
  parameter int unsigned AVG_COUNT   = AvgCountDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ThreshW-1:0]  cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bcs_in_t             in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bcs_out_t                 out_item_o
);

  localparam int unsigned SumW = $clog2(AVG_COUNT * ((2 ** SAMPLE_BITS) - 1) + 1);
  localparam int unsigned ThrW = $clog2(AVG_COUNT * ((2 ** ThreshW) - 1) + 1);
  localparam int unsigned CntW = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;

  localparam logic [ThrW-1:0] ColdSevereScaled = ThrW'(ColdSevereRst * AVG_COUNT);
  localparam logic [ThrW-1:0] ColdScaled       = ThrW'(ColdRst * AVG_COUNT);
  localparam logic [ThrW-1:0] NormalScaled     = ThrW'(NormalRst * AVG_COUNT);
  localparam logic [ThrW-1:0] WarmScaled       = ThrW'(WarmRst * AVG_COUNT);
  localparam logic [CntW-1:0] CntLast          = CntW'(AVG_COUNT - 1);

  // thresholds held pre-multiplied: avg >= t is the same as sum >= t * AVG_COUNT
  logic [ThrW-1:0] thr_csev_q, thr_cold_q, thr_norm_q, thr_warm_q;
  logic [DebW-1:0] deb_ticks_q;

  logic            in_vld_q;
  bcs_in_t         in_q;
  logic            out_vld_q;
  bcs_out_t        out_q, out_d;

  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] count_q, count_d;
  temp_level_e     level_q, level_d;
  deb_t            chg_q, chg_d, done_q, done_d;
  logic            complete_q, complete_d;
  logic            enable_q, enable_d;

  logic            advance;
  logic            last;
  logic [ThrW-1:0] sum_add;
  logic [ThrW-1:0] scaled_wdata;

  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  assign scaled_wdata = ThrW'(cfg_wdata_i) * ThrW'(AVG_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_csev_q  <= ColdSevereScaled;
      thr_cold_q  <= ColdScaled;
      thr_norm_q  <= NormalScaled;
      thr_warm_q  <= WarmScaled;
      deb_ticks_q <= DebounceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgColdSevere: thr_csev_q  <= scaled_wdata;
        CfgCold:       thr_cold_q  <= scaled_wdata;
        CfgNormal:     thr_norm_q  <= scaled_wdata;
        CfgWarm:       thr_warm_q  <= scaled_wdata;
        CfgDebounce:   deb_ticks_q <= cfg_wdata_i[DebW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_add    = ThrW'(sum_q) + ThrW'(in_q.ntc_sample[SAMPLE_BITS-1:0]);
    last       = (count_q == CntLast);
    sum_d      = last ? '0 : SumW'(sum_add);
    count_d    = last ? '0 : count_q + CntW'(1);
    level_d    = level_q;
    chg_d      = chg_q;
    done_d     = done_q;
    complete_d = complete_q;
    enable_d   = enable_q;

    if (last) begin
      if (sum_add >= thr_csev_q) begin
        level_d = LvlColdest;
      end else if (sum_add >= thr_cold_q) begin
        level_d = LvlCold;
      end else if (sum_add >= thr_norm_q) begin
        level_d = LvlNormal;
      end else if (sum_add >= thr_warm_q) begin
        level_d = LvlWarm;
      end else begin
        level_d = LvlHot;
      end
    end

    if (level_d != LvlNormal) begin
      chg_d.cnt  = deb_ticks_q;
      done_d.cnt = deb_ticks_q;
      if (enable_q) begin
        complete_d = 1'b1;
        enable_d   = 1'b0;
      end
    end else if (in_q.dc_removed) begin
      if (enable_q) begin
        complete_d = 1'b1;
        enable_d   = 1'b0;
      end
    end else begin
      enable_d = 1'b1;
      chg_d    = deb_step(chg_q, in_q.status_charging_pin, deb_ticks_q);
      // done pin judged against the freshly debounced charging pin
      if (!done_q.state) begin
        if (in_q.status_done_pin) begin
          complete_d = ~chg_d.state;
        end
      end else if (!in_q.status_done_pin && !chg_d.state) begin
        complete_d = 1'b1;
      end
      done_d = deb_step(done_q, in_q.status_done_pin, deb_ticks_q);
    end

    out_d.temperature_level = level_d;
    out_d.over_limit        = (level_d == LvlColdest) || (level_d == LvlHot);
    out_d.charge_enable     = enable_d;
    out_d.charge_complete   = complete_d;
    out_d.charging_seen     = chg_d.state;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      sum_q      <= '0;
      count_q    <= '0;
      level_q    <= LvlNormal;
      chg_q      <= '{state: 1'b0, cnt: DebounceRst};
      done_q     <= '{state: 1'b0, cnt: DebounceRst};
      complete_q <= 1'b0;
      enable_q   <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q  <= 1'b1;
        sum_q      <= sum_d;
        count_q    <= count_d;
        level_q    <= level_d;
        chg_q      <= chg_d;
        done_q     <= done_d;
        complete_q <= complete_d;
        enable_q   <= enable_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

`include "battery_charge_supervisor_assert.svh"

  // charging can only be on while the temperature level is normal
  `BCS_ASSERT(a_enable_needs_normal, (level_q != LvlNormal) |-> !enable_q)
  // sum restarts from zero whenever the sample count wraps
  `BCS_ASSERT(a_sum_cleared_on_wrap, (count_q == '0) |-> (sum_q == '0))
  // state only moves when an item passes to the result register
  `BCS_ASSERT_NEXT(a_state_holds, !advance, $stable(level_q) && $stable(count_q))
  // a result item leaving unreplaced empties the result register
  `BCS_ASSERT_NEXT(a_out_drains, out_vld_q && out_ready_i && !advance, !out_vld_q)

endmodule

`default_nettype wire
